@@ rtl/i2cm_pkg.sv @@
// i2cm_pkg: shared types, command codes and phase codes for the I2C bit-level master.
// No dependencies; used by i2cm_front, i2cm_back and the top level.
package i2cm_pkg;

	localparam int DELAY_WIDTH = 16;
	localparam int QUEUE_DEPTH = 2;

	// Command codes as seen on the cmd port
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;
	localparam logic [2:0] CMD_SEL7  = 3'd5;
	localparam logic [2:0] CMD_SEL10 = 3'd6;
	localparam logic [2:0] CMD_RSVD  = 3'd7;

	// Bus sequencer phases
	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_ST1  = 4'd1;
	localparam logic [3:0] PH_ST2  = 4'd2;
	localparam logic [3:0] PH_ST3  = 4'd3;
	localparam logic [3:0] PH_ST4  = 4'd4;
	localparam logic [3:0] PH_SP1  = 4'd5;
	localparam logic [3:0] PH_SP2  = 4'd6;
	localparam logic [3:0] PH_SP3  = 4'd7;
	localparam logic [3:0] PH_WL   = 4'd8;
	localparam logic [3:0] PH_WH   = 4'd9;
	localparam logic [3:0] PH_AL   = 4'd10;
	localparam logic [3:0] PH_AH   = 4'd11;
	localparam logic [3:0] PH_RL   = 4'd12;
	localparam logic [3:0] PH_RH   = 4'd13;
	localparam logic [3:0] PH_SL   = 4'd14;
	localparam logic [3:0] PH_SH   = 4'd15;

	// Register address map (byte addresses)
	localparam logic [1:0] ADDR_PHASE_TICKS = 2'd0;
	localparam logic [DELAY_WIDTH-1:0] PHASE_TICKS_RST = DELAY_WIDTH'(5);

	// One classified tick word
	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data;
		logic [9:0] addr;
		logic       rd;
		logic       sack;
		logic       scl;
		logic       sda;
	} item_t;

	// One result word
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy;
		logic       done;
		logic       ack;
		logic       lost;
		logic [7:0] rdata;
	} res_t;

	// Phases that release SCL and so wait out clock stretching
	function automatic logic is_high_phase(input logic [3:0] ph);
		return (ph == PH_ST2) || (ph == PH_SP2) || (ph == PH_WH) ||
			(ph == PH_AH) || (ph == PH_RH) || (ph == PH_SH);
	endfunction

endpackage

@@ rtl/i2cm_front.sv @@
// i2cm_front: input side; accepts tick words, classifies the command code,
// and holds them in a two-entry queue. Depends on i2cm_pkg.
module i2cm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         cmd,
	input  logic [7:0]         data_in,
	input  logic [9:0]         target_address,
	input  logic               read_flag,
	input  logic               send_ack,
	input  logic               scl_in,
	input  logic               sda_in,
	output logic               item_valid,
	output i2cm_pkg::item_t    item,
	input  logic               item_take
);

	i2cm_pkg::item_t mem_q [i2cm_pkg::QUEUE_DEPTH];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      cnt_q;
	logic            wr_en;
	logic            rd_en;
	i2cm_pkg::item_t new_item;

	// Classify: undefined codes become a plain tick
	always_comb begin
		new_item.op = (cmd == i2cm_pkg::CMD_RSVD) ? i2cm_pkg::CMD_NONE : cmd;
		new_item.data = data_in;
		new_item.addr = target_address;
		new_item.rd = read_flag;
		new_item.sack = send_ack;
		new_item.scl = scl_in;
		new_item.sda = sda_in;
	end

	assign full = (cnt_q == 2'(i2cm_pkg::QUEUE_DEPTH));
	assign wr_en = push && !full;
	assign item_valid = (cnt_q != 2'd0);
	assign rd_en = item_take && item_valid;
	assign item = mem_q[rptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= new_item;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wptr_q <= ~wptr_q;
			end
			if (rd_en) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

@@ rtl/i2cm_back.sv @@
// i2cm_back: bus sequencer; steps the I2C state once per tick word and queues
// one result word per tick in a two-entry output queue. Depends on i2cm_pkg.
module i2cm_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [i2cm_pkg::DELAY_WIDTH-1:0] phase_ticks,
	input  logic                             item_valid,
	input  i2cm_pkg::item_t                  item,
	output logic                             item_take,
	output logic                             empty,
	input  logic                             pop,
	output i2cm_pkg::res_t                   res
);

	// Sequencer state
	logic [3:0]                       phase_q, phase_n;
	logic [i2cm_pkg::DELAY_WIDTH-1:0] tick_q, tick_n;
	logic [3:0]                       bit_q, bit_n;
	logic [7:0]                       shift_q, shift_n;
	logic [7:0]                       sec_q, sec_n;
	logic                             lost_q, lost_n;
	logic                             ack_q, ack_n;
	logic [7:0]                       rcv_q, rcv_n;
	logic [2:0]                       op_q, op_n;
	logic                             second_q, second_n;
	logic                             nack_q, nack_n;
	logic                             scl_q, scl_n;
	logic                             sda_q, sda_n;
	logic                             done;
	logic [3:0]                       bit_inc;
	logic [7:0]                       shift_in;

	// Output queue
	i2cm_pkg::res_t oq_q [i2cm_pkg::QUEUE_DEPTH];
	logic           owptr_q;
	logic           orptr_q;
	logic [1:0]     ocnt_q;
	logic           pop_en;
	i2cm_pkg::res_t new_res;

	assign empty = (ocnt_q == 2'd0);
	assign pop_en = pop && !empty;
	assign item_take = item_valid &&
		((ocnt_q != 2'(i2cm_pkg::QUEUE_DEPTH)) || pop_en);
	assign res = oq_q[orptr_q];

	assign bit_inc = bit_q + 4'd1;
	assign shift_in = {shift_q[6:0], item.sda};

	// One tick of the sequencer
	always_comb begin
		phase_n = phase_q;
		tick_n = tick_q;
		bit_n = bit_q;
		shift_n = shift_q;
		sec_n = sec_q;
		lost_n = lost_q;
		ack_n = ack_q;
		rcv_n = rcv_q;
		op_n = op_q;
		second_n = second_q;
		nack_n = nack_q;
		scl_n = scl_q;
		sda_n = sda_q;
		done = 1'b0;
		if (phase_q == i2cm_pkg::PH_IDLE) begin
			// Command decode
			if (item.op != i2cm_pkg::CMD_NONE) begin
				op_n = item.op;
			end
			tick_n = '0;
			unique case (item.op)
				i2cm_pkg::CMD_START: begin
					phase_n = i2cm_pkg::PH_ST1;
					sda_n = 1'b1;
				end
				i2cm_pkg::CMD_SEL7: begin
					shift_n = {item.addr[6:0], item.rd};
					phase_n = i2cm_pkg::PH_ST1;
					sda_n = 1'b1;
				end
				i2cm_pkg::CMD_SEL10: begin
					shift_n = {5'b11110, item.addr[9:8], item.rd};
					sec_n = item.addr[7:0];
					second_n = 1'b1;
					phase_n = i2cm_pkg::PH_ST1;
					sda_n = 1'b1;
				end
				i2cm_pkg::CMD_STOP: begin
					phase_n = i2cm_pkg::PH_SP1;
					sda_n = 1'b0;
				end
				i2cm_pkg::CMD_WRITE: begin
					shift_n = item.data;
					bit_n = 4'd0;
					phase_n = i2cm_pkg::PH_WL;
					scl_n = 1'b0;
					sda_n = item.data[7];
				end
				i2cm_pkg::CMD_READ: begin
					shift_n = 8'd0;
					bit_n = 4'd0;
					nack_n = ~item.sack;
					phase_n = i2cm_pkg::PH_RL;
					scl_n = 1'b0;
					sda_n = 1'b1;
				end
				default: begin
					tick_n = tick_q;
				end
			endcase
		end else if (!(i2cm_pkg::is_high_phase(phase_q) && !item.scl)) begin
			if (({1'b0, tick_q} + (i2cm_pkg::DELAY_WIDTH + 1)'(1)) <
				{1'b0, phase_ticks}) begin
				tick_n = tick_q + (i2cm_pkg::DELAY_WIDTH)'(1);
			end else begin
				// Phase ends: every branch restarts the wait
				tick_n = '0;
				unique case (phase_q)
					i2cm_pkg::PH_ST1: begin
						phase_n = i2cm_pkg::PH_ST2;
						scl_n = 1'b1;
						sda_n = 1'b1;
					end
					i2cm_pkg::PH_ST2: begin
						phase_n = i2cm_pkg::PH_ST3;
						scl_n = 1'b1;
						sda_n = 1'b0;
					end
					i2cm_pkg::PH_ST3: begin
						phase_n = i2cm_pkg::PH_ST4;
						scl_n = 1'b0;
						sda_n = 1'b0;
					end
					i2cm_pkg::PH_ST4: begin
						if (op_q == i2cm_pkg::CMD_START) begin
							phase_n = i2cm_pkg::PH_IDLE;
							done = 1'b1;
						end else begin
							bit_n = 4'd0;
							phase_n = i2cm_pkg::PH_WL;
							scl_n = 1'b0;
							sda_n = shift_q[7];
						end
					end
					i2cm_pkg::PH_SP1: begin
						phase_n = i2cm_pkg::PH_SP2;
						scl_n = 1'b1;
						sda_n = 1'b0;
					end
					i2cm_pkg::PH_SP2: begin
						phase_n = i2cm_pkg::PH_SP3;
						scl_n = 1'b1;
						sda_n = 1'b1;
					end
					i2cm_pkg::PH_SP3: begin
						phase_n = i2cm_pkg::PH_IDLE;
						done = 1'b1;
					end
					i2cm_pkg::PH_WL: begin
						phase_n = i2cm_pkg::PH_WH;
						scl_n = 1'b1;
					end
					i2cm_pkg::PH_WH: begin
						if (sda_q && !item.sda) begin
							// Released SDA read back low: arbitration lost
							lost_n = 1'b1;
							ack_n = 1'b0;
							scl_n = 1'b1;
							sda_n = 1'b1;
							second_n = 1'b0;
							phase_n = i2cm_pkg::PH_IDLE;
							done = 1'b1;
						end else begin
							bit_n = bit_inc;
							scl_n = 1'b0;
							if (bit_inc[3]) begin
								phase_n = i2cm_pkg::PH_AL;
								sda_n = 1'b1;
							end else begin
								phase_n = i2cm_pkg::PH_WL;
								sda_n = shift_q[3'd7 - bit_inc[2:0]];
							end
						end
					end
					i2cm_pkg::PH_AL: begin
						phase_n = i2cm_pkg::PH_AH;
						scl_n = 1'b1;
						sda_n = 1'b1;
					end
					i2cm_pkg::PH_AH: begin
						ack_n = ~item.sda;
						second_n = 1'b0;
						if (op_q == i2cm_pkg::CMD_SEL10 && second_q && !item.sda) begin
							// Second 10-bit address byte
							shift_n = sec_q;
							bit_n = 4'd0;
							phase_n = i2cm_pkg::PH_WL;
							scl_n = 1'b0;
							sda_n = sec_q[7];
						end else begin
							scl_n = 1'b0;
							phase_n = i2cm_pkg::PH_IDLE;
							done = 1'b1;
						end
					end
					i2cm_pkg::PH_RL: begin
						phase_n = i2cm_pkg::PH_RH;
						scl_n = 1'b1;
						sda_n = 1'b1;
					end
					i2cm_pkg::PH_RH: begin
						shift_n = shift_in;
						bit_n = bit_inc;
						scl_n = 1'b0;
						if (bit_inc[3]) begin
							rcv_n = shift_in;
							phase_n = i2cm_pkg::PH_SL;
							sda_n = nack_q;
						end else begin
							phase_n = i2cm_pkg::PH_RL;
							sda_n = 1'b1;
						end
					end
					i2cm_pkg::PH_SL: begin
						phase_n = i2cm_pkg::PH_SH;
						scl_n = 1'b1;
						sda_n = nack_q;
					end
					i2cm_pkg::PH_SH: begin
						scl_n = 1'b0;
						phase_n = i2cm_pkg::PH_IDLE;
						done = 1'b1;
					end
					default: begin
						phase_n = i2cm_pkg::PH_IDLE;
					end
				endcase
			end
		end
	end

	// Result word for this tick
	always_comb begin
		new_res.scl_out = scl_n;
		new_res.sda_out = sda_n;
		new_res.busy = (phase_n != i2cm_pkg::PH_IDLE);
		new_res.done = done;
		new_res.ack = ack_n;
		new_res.lost = lost_n;
		new_res.rdata = rcv_n;
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cm_pkg::PH_IDLE;
			tick_q <= '0;
			bit_q <= 4'd0;
			shift_q <= 8'd0;
			sec_q <= 8'd0;
			lost_q <= 1'b0;
			ack_q <= 1'b0;
			rcv_q <= 8'd0;
			op_q <= i2cm_pkg::CMD_NONE;
			second_q <= 1'b0;
			nack_q <= 1'b0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
		end else if (item_take) begin
			phase_q <= phase_n;
			tick_q <= tick_n;
			bit_q <= bit_n;
			shift_q <= shift_n;
			sec_q <= sec_n;
			lost_q <= lost_n;
			ack_q <= ack_n;
			rcv_q <= rcv_n;
			op_q <= op_n;
			second_q <= second_n;
			nack_q <= nack_n;
			scl_q <= scl_n;
			sda_q <= sda_n;
		end
	end

	// Output queue storage
	always_ff @(posedge clk) begin
		if (item_take) begin
			oq_q[owptr_q] <= new_res;
		end
	end

	// Output queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= 1'b0;
			orptr_q <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (item_take) begin
				owptr_q <= ~owptr_q;
			end
			if (pop_en) begin
				orptr_q <= ~orptr_q;
			end
			ocnt_q <= ocnt_q + 2'(item_take) - 2'(pop_en);
		end
	end

endmodule

@@ rtl/i2c_bit_level_master.sv @@
// I2C bit-level master, top level: APB register, input queue, sequencer.
// Depends on i2cm_pkg, i2cm_front, i2cm_back.
// Path: a tick word waits in the input queue; its result word is registered into the output queue.
// Throughput: one tick word per cycle while the output queue has room; the sequencer steps once per word.
// Reset (arst_n low): queues empty, sequencer idle, lines released, phase_ticks = 5.
module i2c_bit_level_master (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// tick words in
	input  logic        push,
	output logic        full,
	input  logic [2:0]  cmd,
	input  logic [7:0]  data_in,
	input  logic [9:0]  target_address,
	input  logic        read_flag,
	input  logic        send_ack,
	input  logic        scl_in,
	input  logic        sda_in,
	// result words out
	output logic        empty,
	input  logic        pop,
	output logic        scl_out,
	output logic        sda_out,
	output logic        busy_res,
	output logic        done_res,
	output logic        ack_received,
	output logic        arbitration_lost,
	output logic [7:0]  read_data
);

	logic [i2cm_pkg::DELAY_WIDTH-1:0] phase_ticks_q;
	logic                             item_valid;
	logic                             item_take;
	i2cm_pkg::item_t                  item;
	i2cm_pkg::res_t                   res;

	// Register file: a single timing register
	assign pready = 1'b1;
	assign prdata = (paddr == i2cm_pkg::ADDR_PHASE_TICKS) ?
		32'(phase_ticks_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cm_pkg::PHASE_TICKS_RST;
		end else if (psel && penable && pwrite && pready) begin
			phase_ticks_q <= pwdata[i2cm_pkg::DELAY_WIDTH-1:0];
		end
	end

	i2cm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.cmd            (cmd),
		.data_in        (data_in),
		.target_address (target_address),
		.read_flag      (read_flag),
		.send_ack       (send_ack),
		.scl_in         (scl_in),
		.sda_in         (sda_in),
		.item_valid     (item_valid),
		.item           (item),
		.item_take      (item_take)
	);

	i2cm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.phase_ticks (phase_ticks_q),
		.item_valid  (item_valid),
		.item        (item),
		.item_take   (item_take),
		.empty       (empty),
		.pop         (pop),
		.res         (res)
	);

	assign scl_out = res.scl_out;
	assign sda_out = res.sda_out;
	assign busy_res = res.busy;
	assign done_res = res.done;
	assign ack_received = res.ack;
	assign arbitration_lost = res.lost;
	assign read_data = res.rdata;

endmodule

@@ rtl/i2cm_checker.sv @@
// i2cm_checker: port-level assertions for i2c_bit_level_master, bound to the top.
// Depends only on the top level's ports.
module i2cm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic       busy_res,
	input logic       done_res,
	input logic       arbitration_lost,
	input logic [7:0] read_data
);

	logic [2:0] outst_q;
	logic       lost_seen_q;
	logic       in_fire;
	logic       out_fire;

	assign in_fire = push && !full;
	assign out_fire = pop && !empty;

	// Words in flight and sticky loss seen on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= 3'd0;
			lost_seen_q <= 1'b0;
		end else begin
			outst_q <= outst_q + 3'(in_fire) - 3'(out_fire);
			if (out_fire && arbitration_lost) begin
				lost_seen_q <= 1'b1;
			end
		end
	end

	// A finished command leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && done_res |-> !busy_res)
		else $error("done word shows busy");

	// Loss flag never drops once delivered
	a_lost_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && lost_seen_q |-> arbitration_lost)
		else $error("arbitration_lost cleared");

	// One result per input word, at most four in flight
	a_outstanding: assert property (@(posedge clk) disable iff (!arst_n)
		(outst_q <= 3'd4) && (empty || (outst_q != 3'd0)))
		else $error("result count out of step with inputs");

	// Waiting result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(read_data))
		else $error("waiting result changed");

endmodule

bind i2c_bit_level_master i2cm_checker u_i2cm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.push             (push),
	.full             (full),
	.empty            (empty),
	.pop              (pop),
	.busy_res         (busy_res),
	.done_res         (done_res),
	.arbitration_lost (arbitration_lost),
	.read_data        (read_data)
);
